FILE: src/metronome_beat_generator_assert.svh
`ifndef METRONOME_BEAT_GENERATOR_ASSERT_SVH
`define METRONOME_BEAT_GENERATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MBG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("metronome_beat_generator: check failed");

// next-cycle implication, checked out of reset
`define MBG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("metronome_beat_generator: check failed");

`endif

FILE: src/mbg_pkg.sv
package mbg_pkg;

    localparam int SamplesPerReading = 10;
    localparam int SampleW           = 8;
    localparam int ByteW             = 8;
    localparam int TempoDivisor      = 15;
    localparam int RecipShift        = 15;
    localparam int RecipMult         = (2 ** RecipShift + TempoDivisor - 1) / TempoDivisor;
    localparam int RecipW            = 12;

    localparam logic [ByteW-1:0] LongBeepRst   = 8'd6;
    localparam logic [ByteW-1:0] ShortBeepRst  = 8'd3;
    localparam logic [ByteW-1:0] WaitOffsetRst = 8'd5;
    localparam logic [ByteW-1:0] BarLenRst     = 8'd4;
    localparam logic [ByteW-1:0] ByteMax       = 8'd255;

    localparam int CfgIdxW = 2;
    localparam logic [CfgIdxW-1:0] CfgLongBeep   = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgShortBeep  = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgWaitOffset = 2'd2;

    localparam int InTdataW  = 8;
    localparam int InTuserW  = 2;
    localparam int OutTdataW = 24;
    localparam int OutPadW   = 4;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_TICK   = 2'd1,
        MODE_UP     = 2'd2,
        MODE_DOWN   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        PH_SAMPLE = 2'd0,
        PH_WAIT   = 2'd1,
        PH_BEEP   = 2'd2
    } t_phase;

    typedef struct packed {
        logic [ByteW-1:0] long_beep;
        logic [ByteW-1:0] short_beep;
        logic [ByteW-1:0] wait_offset;
    } t_cfg;

    typedef struct packed {
        logic             beep_on;
        logic             accent;
        logic [ByteW-1:0] bar_length;
        logic [ByteW-1:0] beat_index;
        t_phase           phase_now;
    } t_result;

endpackage

FILE: src/mbg_tempo.sv
module mbg_tempo #(
    parameter int TotalW = 12
) (
    input  logic [TotalW-1:0]        i_total,
    input  logic [mbg_pkg::ByteW-1:0] i_offset,
    output logic [mbg_pkg::ByteW-1:0] o_wait
);

    localparam int ProdW = TotalW + mbg_pkg::RecipW;
    localparam int QuotW = ProdW - mbg_pkg::RecipShift;
    localparam int SumW  = ((QuotW > mbg_pkg::ByteW) ? QuotW : mbg_pkg::ByteW) + 1;

    logic [ProdW-1:0] w_prod;
    logic [QuotW-1:0] w_quot;
    logic [SumW-1:0]  w_sum;

    // divide by the tempo divisor through a scaled reciprocal
    assign w_prod = ProdW'(i_total) * ProdW'(mbg_pkg::RecipMult);
    assign w_quot = w_prod[ProdW-1:mbg_pkg::RecipShift];
    assign w_sum  = SumW'(w_quot) + SumW'(i_offset);
    assign o_wait = (w_sum > SumW'(mbg_pkg::ByteMax)) ? mbg_pkg::ByteMax
                                                       : w_sum[mbg_pkg::ByteW-1:0];

endmodule

FILE: src/mbg_core.sv
module mbg_core #(
    parameter int SamplesPerReading = mbg_pkg::SamplesPerReading
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_fire,
    input  mbg_pkg::t_mode            i_mode,
    input  logic [mbg_pkg::SampleW-1:0] i_sample,
    input  mbg_pkg::t_cfg             i_cfg,
    output mbg_pkg::t_result          o_result
);

    localparam int CntW   = $clog2(SamplesPerReading + 1);
    localparam int TotalW = mbg_pkg::SampleW + CntW;
    localparam int BW     = mbg_pkg::ByteW;

    mbg_pkg::t_phase r_phase, n_phase;
    logic [CntW-1:0]   r_cnt, n_cnt;
    logic [TotalW-1:0] r_total, n_total;
    logic [BW-1:0]     r_wait, n_wait;
    logic [BW-1:0]     r_beep, n_beep;
    logic [BW-1:0]     r_pos, n_pos;
    logic [BW-1:0]     r_bars, n_bars;
    logic              r_accent, n_accent;

    logic [TotalW-1:0] w_total_sum;
    logic [CntW-1:0]   w_cnt_inc;
    logic              w_reading_done;
    logic [BW-1:0]     w_wait_calc;
    logic [BW-1:0]     w_wait_dec;
    logic [BW-1:0]     w_beep_dec;
    logic              w_first;
    logic [BW-1:0]     w_len_raw;
    logic [BW-1:0]     w_len;
    logic [BW-1:0]     w_pos_inc;
    logic [BW-1:0]     w_pos_beat;
    logic              w_sample_ok;
    logic              w_start;

    assign w_total_sum    = r_total + TotalW'(i_sample);
    assign w_cnt_inc      = r_cnt + CntW'(1);
    assign w_reading_done = (w_cnt_inc == CntW'(SamplesPerReading));

    mbg_tempo #(
        .TotalW(TotalW)
    ) u_tempo (
        .i_total (w_total_sum),
        .i_offset(i_cfg.wait_offset),
        .o_wait  (w_wait_calc)
    );

    assign w_wait_dec = (r_wait != '0) ? r_wait - BW'(1) : '0;
    assign w_beep_dec = (r_beep != '0) ? r_beep - BW'(1) : '0;

    assign w_first    = (r_pos == '0);
    assign w_len_raw  = w_first ? i_cfg.long_beep : i_cfg.short_beep;
    assign w_len      = (w_len_raw == '0) ? BW'(1) : w_len_raw;
    assign w_pos_inc  = r_pos + BW'(1);
    assign w_pos_beat = (!w_first && (w_pos_inc >= r_bars)) ? '0 : w_pos_inc;

    assign w_sample_ok = (i_mode == mbg_pkg::MODE_SAMPLE) && (r_phase == mbg_pkg::PH_SAMPLE)
                         && w_reading_done;
    assign w_start = (w_sample_ok && (w_wait_calc == '0))
                     || ((i_mode == mbg_pkg::MODE_TICK) && (r_phase == mbg_pkg::PH_WAIT)
                         && (w_wait_dec == '0));

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (w_start) begin
            n_phase = mbg_pkg::PH_BEEP;
        end else if (w_sample_ok) begin
            n_phase = mbg_pkg::PH_WAIT;
        end else if ((i_mode == mbg_pkg::MODE_TICK) && (r_phase == mbg_pkg::PH_BEEP)
                     && (w_beep_dec == '0)) begin
            n_phase = mbg_pkg::PH_SAMPLE;
        end
    end

    // counters and bar position
    always_comb begin
        n_cnt    = r_cnt;
        n_total  = r_total;
        n_wait   = r_wait;
        n_beep   = r_beep;
        n_pos    = r_pos;
        n_bars   = r_bars;
        n_accent = r_accent;
        unique case (i_mode)
            mbg_pkg::MODE_SAMPLE: begin
                if (r_phase == mbg_pkg::PH_SAMPLE) begin
                    if (w_reading_done) begin
                        n_cnt   = '0;
                        n_total = '0;
                        n_wait  = w_wait_calc;
                    end else begin
                        n_cnt   = w_cnt_inc;
                        n_total = w_total_sum;
                    end
                end
            end
            mbg_pkg::MODE_TICK: begin
                if (r_phase == mbg_pkg::PH_WAIT) begin
                    n_wait = w_wait_dec;
                end else if (r_phase == mbg_pkg::PH_BEEP) begin
                    n_beep = w_beep_dec;
                    if (w_beep_dec == '0) begin
                        n_accent = 1'b0;
                    end
                end
            end
            mbg_pkg::MODE_UP: begin
                if (r_bars != mbg_pkg::ByteMax) begin
                    n_bars = r_bars + BW'(1);
                end
            end
            mbg_pkg::MODE_DOWN: begin
                if (r_bars != '0) begin
                    n_bars = r_bars - BW'(1);
                end
            end
        endcase
        if (w_start) begin
            n_accent = w_first;
            n_beep   = w_len;
            n_pos    = w_pos_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= mbg_pkg::PH_SAMPLE;
            r_cnt    <= '0;
            r_total  <= '0;
            r_wait   <= '0;
            r_beep   <= '0;
            r_pos    <= '0;
            r_bars   <= mbg_pkg::BarLenRst;
            r_accent <= 1'b0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_total  <= n_total;
            r_wait   <= n_wait;
            r_beep   <= n_beep;
            r_pos    <= n_pos;
            r_bars   <= n_bars;
            r_accent <= n_accent;
        end
    end

    assign o_result.beep_on    = (n_phase == mbg_pkg::PH_BEEP);
    assign o_result.accent     = (n_phase == mbg_pkg::PH_BEEP) && n_accent;
    assign o_result.bar_length = n_bars;
    assign o_result.beat_index = n_pos;
    assign o_result.phase_now  = n_phase;

endmodule

FILE: src/metronome_beat_generator.sv
// Throughput: one transaction per cycle while i_m_tready is high. An accepted input
// transaction is held in the input register, then its result in the result register;
// each holds one item, so a new item is taken while a result waits for i_m_tready.
// Reset: synchronous, active low; beat state clears, beats per bar returns to 4 and the
// pulse and offset registers return to 6, 3 and 5.
`include "metronome_beat_generator_assert.svh"

module metronome_beat_generator #(
    parameter int SamplesPerReading = mbg_pkg::SamplesPerReading
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [mbg_pkg::InTdataW-1:0]  i_s_tdata,  // [7:0] sample_value
    input  logic [mbg_pkg::InTuserW-1:0]  i_s_tuser,  // [1:0] mode
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [0] beep_on, [1] accent, [9:2] bar_length, [17:10] beat_index, [19:18] phase_now
    output logic [mbg_pkg::OutTdataW-1:0] o_m_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mbg_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [mbg_pkg::ByteW-1:0]     i_cfg_data
);

    mbg_pkg::t_cfg    r_cfg;
    logic             r_in_valid;
    mbg_pkg::t_mode   r_in_mode;
    logic [mbg_pkg::SampleW-1:0] r_in_sample;
    logic             r_out_valid;
    mbg_pkg::t_result r_out;

    logic             w_out_load;
    logic             w_adv;
    mbg_pkg::t_result w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_beep   <= mbg_pkg::LongBeepRst;
            r_cfg.short_beep  <= mbg_pkg::ShortBeepRst;
            r_cfg.wait_offset <= mbg_pkg::WaitOffsetRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mbg_pkg::CfgLongBeep:   r_cfg.long_beep   <= i_cfg_data;
                mbg_pkg::CfgShortBeep:  r_cfg.short_beep  <= i_cfg_data;
                mbg_pkg::CfgWaitOffset: r_cfg.wait_offset <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_out_load = !r_out_valid || i_m_tready;
    assign w_adv      = r_in_valid && w_out_load;
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_mode   <= mbg_pkg::t_mode'(i_s_tuser);
            r_in_sample <= i_s_tdata;
        end
    end

    mbg_core #(
        .SamplesPerReading(SamplesPerReading)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_adv),
        .i_mode  (r_in_mode),
        .i_sample(r_in_sample),
        .i_cfg   (r_cfg),
        .o_result(w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {mbg_pkg::OutPadW'(0), r_out.phase_now, r_out.beat_index,
                         r_out.bar_length, r_out.accent, r_out.beep_on};

    `MBG_ASSERT_NOW(a_beep_matches_phase, o_m_tvalid,
                    o_m_tdata[0] == (o_m_tdata[19:18] == 2'(mbg_pkg::PH_BEEP)))
    `MBG_ASSERT_NOW(a_accent_needs_beep, o_m_tvalid, !o_m_tdata[1] || o_m_tdata[0])
    `MBG_ASSERT_NEXT(a_advance_gives_result, w_adv, o_m_tvalid)

endmodule

FILE: dv/tb_metronome_beat_generator.sv
`timescale 1ns / 100ps

module tb_metronome_beat_generator;
    import mbg_pkg::*;

    localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

    typedef struct packed {
        bit                  is_write;
        t_mode               mode;
        logic [ByteW-1:0]    value;
        logic [CfgIdxW-1:0]  reg_index;
        logic [ByteW-1:0]    repeats;
        bit                  typed;
        t_result             want;
    } t_step;

    typedef struct packed {
        logic [ByteW-1:0] long_len;
        logic [ByteW-1:0] short_len;
        logic [ByteW-1:0] offset;
        int unsigned      count;
        logic [ByteW-1:0] cap;
        bit               steady;
        bit               push;
        t_mode            push_mode;
    } t_phase_plan;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [InTdataW-1:0]  i_s_tdata   = '0;   // [7:0] sample_value
    logic [InTuserW-1:0]  i_s_tuser   = '0;   // [1:0] mode
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    // [0] beep_on, [1] accent, [9:2] bar_length, [17:10] beat_index, [19:18] phase_now
    logic [OutTdataW-1:0] o_m_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CfgIdxW-1:0]   i_cfg_index = '0;
    logic [ByteW-1:0]     i_cfg_data  = '0;

    t_cfg             cfg_regs;
    t_phase           beat_phase;
    logic [3:0]       samples_in;
    logic [11:0]      tempo_sum;
    logic [ByteW-1:0] wait_left;
    logic [ByteW-1:0] beep_left;
    logic [ByteW-1:0] beat_pos;
    logic [ByteW-1:0] bar_len;
    bit               long_pulse;

    t_result pending_status[$];
    int      fault_count = 0;
    bit      no_gaps     = 1'b0;

    t_step directed_plan [13] = '{
        '{1'b0, MODE_UP,     8'd0,   CfgLongBeep,   8'd1,  1'b1,
          '{1'b0, 1'b0, 8'd5, 8'd0, PH_SAMPLE}},
        '{1'b0, MODE_DOWN,   8'd0,   CfgLongBeep,   8'd1,  1'b1,
          '{1'b0, 1'b0, 8'd4, 8'd0, PH_SAMPLE}},
        '{1'b0, MODE_TICK,   8'd0,   CfgLongBeep,   8'd1,  1'b1,
          '{1'b0, 1'b0, 8'd4, 8'd0, PH_SAMPLE}},
        '{1'b1, MODE_SAMPLE, 8'd0,   CfgWaitOffset, 8'd1,  1'b0, '0},
        '{1'b1, MODE_SAMPLE, 8'd0,   CfgLongBeep,   8'd1,  1'b0, '0},
        '{1'b0, MODE_SAMPLE, 8'd0,   CfgLongBeep,   8'd9,  1'b0, '0},
        '{1'b0, MODE_SAMPLE, 8'd14,  CfgLongBeep,   8'd1,  1'b0, '0},
        '{1'b0, MODE_SAMPLE, 8'd255, CfgLongBeep,   8'd1,  1'b0, '0},
        '{1'b0, MODE_TICK,   8'd0,   CfgLongBeep,   8'd1,  1'b0, '0},
        '{1'b1, MODE_SAMPLE, 8'd0,   CfgShortBeep,  8'd1,  1'b0, '0},
        '{1'b0, MODE_SAMPLE, 8'd0,   CfgLongBeep,   8'd10, 1'b0, '0},
        '{1'b0, MODE_TICK,   8'd0,   CfgLongBeep,   8'd1,  1'b0, '0},
        '{1'b0, MODE_UP,     8'd0,   CfgLongBeep,   8'd1,  1'b0, '0}
    };

    t_phase_plan phase_plans [5] = '{
        '{8'd6,   8'd3,   8'd5,   60,  8'd30,  1'b0, 1'b0, MODE_UP},
        '{8'd1,   8'd2,   8'd0,   90,  8'd1,   1'b0, 1'b1, MODE_DOWN},
        '{8'd0,   8'd0,   8'd1,   70,  8'd20,  1'b1, 1'b0, MODE_UP},
        '{8'd255, 8'd255, 8'd255, 290, 8'd255, 1'b0, 1'b1, MODE_UP},
        '{8'd3,   8'd1,   8'd2,   50,  8'd10,  1'b0, 1'b0, MODE_UP}
    };

    metronome_beat_generator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit take_break();
        return !no_gaps && ($urandom_range(99) < 13);
    endfunction

    function automatic void begin_beat();
        logic [ByteW-1:0] len;
        long_pulse = (beat_pos == '0);
        len = long_pulse ? cfg_regs.long_beep : cfg_regs.short_beep;
        if (len == '0)
            len = 8'd1;
        beep_left = len;
        beat_pos = beat_pos + 8'd1;
        if (!long_pulse && beat_pos >= bar_len)
            beat_pos = '0;
        beat_phase = PH_BEEP;
    endfunction

    function automatic t_result advance_metronome(t_mode mode, logic [ByteW-1:0] sample);
        int      wait_ticks;
        t_result status;
        case (mode)
            MODE_SAMPLE: begin
                if (beat_phase == PH_SAMPLE) begin
                    tempo_sum = tempo_sum + 12'(sample);
                    samples_in = samples_in + 4'd1;
                    if (samples_in >= SamplesPerReading) begin
                        wait_ticks = int'(tempo_sum) / TempoDivisor + int'(cfg_regs.wait_offset);
                        if (wait_ticks > int'(ByteMax))
                            wait_ticks = int'(ByteMax);
                        tempo_sum = '0;
                        samples_in = '0;
                        wait_left = ByteW'(wait_ticks);
                        if (wait_ticks == 0)
                            begin_beat();
                        else
                            beat_phase = PH_WAIT;
                    end
                end
            end
            MODE_TICK: begin
                if (beat_phase == PH_WAIT) begin
                    if (wait_left != '0)
                        wait_left = wait_left - 8'd1;
                    if (wait_left == '0)
                        begin_beat();
                end else if (beat_phase == PH_BEEP) begin
                    if (beep_left != '0)
                        beep_left = beep_left - 8'd1;
                    if (beep_left == '0) begin
                        beat_phase = PH_SAMPLE;
                        long_pulse = 1'b0;
                    end
                end
            end
            MODE_UP: begin
                if (bar_len != ByteMax)
                    bar_len = bar_len + 8'd1;
            end
            default: begin
                if (bar_len != '0)
                    bar_len = bar_len - 8'd1;
            end
        endcase
        status.beep_on    = (beat_phase == PH_BEEP);
        status.accent     = (beat_phase == PH_BEEP) && long_pulse;
        status.bar_length = bar_len;
        status.beat_index = beat_pos;
        status.phase_now  = beat_phase;
        return status;
    endfunction

    task automatic report_fault(string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fault_count++;
    endtask

    task automatic send_item(t_mode mode, logic [ByteW-1:0] sample, bit typed, t_result want);
        t_result status;
        while (take_break()) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= sample;
        do @(posedge i_clk); while (!o_s_tready);
        status = advance_metronome(mode, sample);
        pending_status.push_back(typed ? want : status);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] data);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CfgLongBeep:   cfg_regs.long_beep   = data;
            CfgShortBeep:  cfg_regs.short_beep  = data;
            CfgWaitOffset: cfg_regs.wait_offset = data;
            default: ;
        endcase
    endtask

    task automatic random_item(logic [ByteW-1:0] cap);
        int               pick;
        t_mode            mode;
        logic [ByteW-1:0] sample;
        pick   = $urandom_range(99);
        sample = ByteW'($urandom_range(255));
        if (pick < 4)
            mode = MODE_UP;
        else if (pick < 8)
            mode = MODE_DOWN;
        else if (pick < 14)
            mode = t_mode'($urandom_range(3));
        else if (beat_phase == PH_SAMPLE) begin
            mode = MODE_SAMPLE;
            if ($urandom_range(9) != 0)
                sample = ByteW'($urandom_range(int'(cap)));
        end else
            mode = MODE_TICK;
        send_item(mode, sample, 1'b0, '0);
    endtask

    always @(posedge i_clk)
        i_m_tready <= !take_break();

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_status.size() == 0)
                report_fault($sformatf("result 0x%06h with nothing expected", o_m_tdata));
            else begin
                want = pending_status.pop_front();
                if (o_m_tdata[0] !== want.beep_on)
                    report_fault($sformatf("beep_on got %0d want %0d",
                                           o_m_tdata[0], want.beep_on));
                if (o_m_tdata[1] !== want.accent)
                    report_fault($sformatf("accent got %0d want %0d",
                                           o_m_tdata[1], want.accent));
                if (o_m_tdata[9:2] !== want.bar_length)
                    report_fault($sformatf("bar_length got %0d want %0d",
                                           o_m_tdata[9:2], want.bar_length));
                if (o_m_tdata[17:10] !== want.beat_index)
                    report_fault($sformatf("beat_index got %0d want %0d",
                                           o_m_tdata[17:10], want.beat_index));
                if (o_m_tdata[19:18] !== want.phase_now)
                    report_fault($sformatf("phase_now got %0d want %0d",
                                           o_m_tdata[19:18], want.phase_now));
                if (o_m_tdata[OutTdataW-1:20] !== '0)
                    report_fault($sformatf("padding got 0x%0h", o_m_tdata[OutTdataW-1:20]));
            end
        end
    end

    initial begin
        cfg_regs.long_beep   = LongBeepRst;
        cfg_regs.short_beep  = ShortBeepRst;
        cfg_regs.wait_offset = WaitOffsetRst;
        beat_phase = PH_SAMPLE;
        samples_in = '0;
        tempo_sum  = '0;
        wait_left  = '0;
        beep_left  = '0;
        beat_pos   = '0;
        bar_len    = BarLenRst;
        long_pulse = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[i]) begin
            if (directed_plan[i].is_write)
                write_register(directed_plan[i].reg_index, directed_plan[i].value);
            else
                repeat (directed_plan[i].repeats)
                    send_item(directed_plan[i].mode, directed_plan[i].value,
                              directed_plan[i].typed, directed_plan[i].want);
        end

        write_register(CfgUnused, ByteW'($urandom_range(255)));

        foreach (phase_plans[p]) begin
            write_register(CfgLongBeep,   phase_plans[p].long_len);
            write_register(CfgShortBeep,  phase_plans[p].short_len);
            write_register(CfgWaitOffset, phase_plans[p].offset);
            no_gaps = phase_plans[p].steady;
            if (phase_plans[p].push) begin
                // drive beats per bar into its limit, then press past it
                while ((phase_plans[p].push_mode == MODE_UP && bar_len != ByteMax) ||
                       (phase_plans[p].push_mode == MODE_DOWN && bar_len != '0))
                    send_item(phase_plans[p].push_mode, ByteW'($urandom_range(255)),
                              1'b0, '0);
                repeat (3)
                    send_item(phase_plans[p].push_mode, ByteW'($urandom_range(255)),
                              1'b0, '0);
            end
            repeat (phase_plans[p].count)
                random_item(phase_plans[p].cap);
            no_gaps = 1'b0;
        end

        wait_drained();
        if (fault_count == 0)
            $display("metronome_beat_generator test passed");
        else
            $display("metronome_beat_generator test failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("metronome_beat_generator test failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/mbg_pkg.sv
src/mbg_tempo.sv
src/mbg_core.sv
src/metronome_beat_generator.sv
dv/tb_metronome_beat_generator.sv
